// File: rtl/core/hmnm_pkg.sv
// Package: item types, field widths and codes for the mutual nearest matcher.
`timescale 1ns / 1ps

package hmnm_pkg;

    // Field widths of the channel items.
    localparam int KIND_W  = 2;
    localparam int PIDX_W  = 10;
    localparam int WIDX_W  = 3;
    localparam int WORD_W  = 64;
    localparam int MIDX_W  = 10;
    localparam int MDIST_W = 9;
    localparam int COUNT_W = 11;
    localparam int POP_W   = 7;

    // Largest distance that the result field can carry.
    localparam int DIST_MAX = 511;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY       = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FIRST_COUNT  = 1'b0;
    localparam logic CFG_SECOND_COUNT = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PIDX_W-1:0] point_index;
        logic [WIDX_W-1:0] word_index;
        logic [WORD_W-1:0] word_value;
    } t_in_item;

    typedef struct packed {
        logic [MIDX_W-1:0]  match_index;
        logic [MDIST_W-1:0] match_distance;
        logic               is_mutual;
        logic               bad_query;
    } t_out_item;

    // Number of set bits in one 64-bit word.
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [POP_W-1:0] s;
        s = '0;
        for (int b = 0; b < WORD_W; b++) begin
            s = s + POP_W'(v[b]);
        end
        return s;
    endfunction

endpackage

// File: rtl/core/hmnm_store.sv
// Descriptor store: one row per descriptor, written a word at a time, read a row at a time.
`timescale 1ns / 1ps

module hmnm_store #(
    parameter int ROWS  = 1024,
    parameter int WORDS = 6
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [$clog2(ROWS)-1:0]                  i_wr_row,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] i_wr_word,
    input  logic [hmnm_pkg::WORD_W-1:0]              i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [$clog2(ROWS)-1:0]                  i_rd_row,
    output logic [WORDS-1:0][hmnm_pkg::WORD_W-1:0]   o_rd_data
);

    logic [WORDS-1:0][hmnm_pkg::WORD_W-1:0] r_mem [ROWS];

    // Word-lane write into the addressed row.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_word] <= i_wr_data;
        end
    end

    // Registered row read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_row];
        end
    end

endmodule

// File: rtl/core/hmnm_dist.sv
// Shared distance unit: XOR and popcount against a key, then a running minimum.
`timescale 1ns / 1ps

module hmnm_dist #(
    parameter int WORDS = 6,
    parameter int IDX_W = 10,
    parameter int DW    = 9
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [WORDS-1:0][hmnm_pkg::WORD_W-1:0] i_key,
    input  logic                                   i_clear,
    input  logic                                   i_cand_valid,
    input  logic [IDX_W-1:0]                       i_cand_index,
    input  logic [WORDS-1:0][hmnm_pkg::WORD_W-1:0] i_cand_data,
    output logic                                   o_busy,
    output logic [IDX_W-1:0]                       o_best_index,
    output logic [DW-1:0]                          o_best_dist
);

    logic                                   r_s1_valid;
    logic [IDX_W-1:0]                       r_s1_index;
    logic [WORDS-1:0][hmnm_pkg::POP_W-1:0]  r_s1_pop;
    logic                                   r_have;
    logic [DW-1:0]                          n_sum;

    // Stage one: per-word popcount of the XOR with the key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cand_valid;
        end
        r_s1_index <= i_cand_index;
        for (int w = 0; w < WORDS; w++) begin
            r_s1_pop[w] <= hmnm_pkg::popcount64(i_key[w] ^ i_cand_data[w]);
        end
    end

    // Stage two: sum of the word counts.
    always_comb begin
        n_sum = '0;
        for (int w = 0; w < WORDS; w++) begin
            n_sum = n_sum + DW'(r_s1_pop[w]);
        end
    end

    // Keep the first strictly smaller distance, so ties stay with the lowest index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (r_s1_valid && (!r_have || n_sum < o_best_dist)) begin
            r_have <= 1'b1;
        end
        if (r_s1_valid && (!r_have || n_sum < o_best_dist)) begin
            o_best_index <= r_s1_index;
            o_best_dist  <= n_sum;
        end
    end

    assign o_busy = r_s1_valid;

endmodule

// File: rtl/core/hamming_mutual_nearest_match_top.sv
// Top level of the mutual nearest matcher: handshakes, configuration and the query sequencer.
`timescale 1ns / 1ps

// The input channel carries load and query items; a transfer takes place when
// i_in_valid is high and o_in_stall is low. A load writes one 64-bit word of a
// first-set or second-set descriptor and gives no result. A query names a
// first-set point; the block reads it, scans the second set one descriptor per
// cycle through the shared distance unit, then reads the match and scans the
// first set the same way. Each scan covers the effective count of its set, and
// the next item is taken once the result is loaded into the output register.
// A query outside the first set skips both scans and goes straight to its flagged
// result. One query is in flight at a time; o_in_stall is high while it runs.
// The result waits in an output register until the receiver takes it; while
// i_out_stall holds it back, loads are still taken, and a finished query waits
// for the register to empty. The configuration channel is always ready.
// Reset empties the output register, returns the sequencer to idle and sets
// both counts to one; the descriptor stores are not cleared.
module hamming_mutual_nearest_match_top #(
    parameter int MAX_POINTS = 1024,
    parameter int DESC_WORDS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  hmnm_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output hmnm_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [hmnm_pkg::COUNT_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int WSEL_W = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
    localparam int DW = $clog2(DESC_WORDS * hmnm_pkg::WORD_W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY1,
        S_KEYW1,
        S_SCAN2,
        S_DRAIN2,
        S_KEY2,
        S_KEYW2,
        S_SCAN1,
        S_DRAIN1,
        S_OUT
    } t_state;

    t_state                                 r_state;
    logic [hmnm_pkg::COUNT_W-1:0]           r_first_count;
    logic [hmnm_pkg::COUNT_W-1:0]           r_second_count;
    logic [IDX_W-1:0]                       r_q;
    logic [IDX_W-1:0]                       r_cnt;
    logic [IDX_W-1:0]                       r_last;
    logic [IDX_W-1:0]                       r_match;
    logic [DW-1:0]                          r_mdist;
    logic                                   r_mutual;
    logic                                   r_bad;
    logic [DESC_WORDS-1:0][hmnm_pkg::WORD_W-1:0] r_key;
    logic                                   r_iss_v;
    logic                                   r_iss_sel;
    logic [IDX_W-1:0]                       r_iss_idx;

    logic                                   in_xfer;
    logic                                   out_xfer;
    logic [31:0]                            eff_first;
    logic [31:0]                            eff_second;
    logic [IDX_W-1:0]                       last_first;
    logic [IDX_W-1:0]                       last_second;
    logic [31:0]                            pidx32;
    logic                                   load_ok;
    logic                                   first_wr;
    logic                                   second_wr;
    logic                                   first_rd;
    logic                                   second_rd;
    logic [IDX_W-1:0]                       first_rd_row;
    logic [IDX_W-1:0]                       second_rd_row;
    logic [DESC_WORDS-1:0][hmnm_pkg::WORD_W-1:0] first_rd_data;
    logic [DESC_WORDS-1:0][hmnm_pkg::WORD_W-1:0] second_rd_data;
    logic                                   dist_clear;
    logic                                   dist_busy;
    logic [IDX_W-1:0]                       best_index;
    logic [DW-1:0]                          best_dist;
    logic [31:0]                            match32;
    logic [31:0]                            dist32;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count  <= hmnm_pkg::COUNT_W'(1);
            r_second_count <= hmnm_pkg::COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hmnm_pkg::CFG_FIRST_COUNT:  r_first_count  <= i_cfg_data;
                hmnm_pkg::CFG_SECOND_COUNT: r_second_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective counts: zero acts as one, and the count is capped at the store size.
    always_comb begin
        if (r_first_count == '0) begin
            eff_first = 32'd1;
        end else if (32'(r_first_count) > 32'(MAX_POINTS)) begin
            eff_first = 32'(MAX_POINTS);
        end else begin
            eff_first = 32'(r_first_count);
        end
        if (r_second_count == '0) begin
            eff_second = 32'd1;
        end else if (32'(r_second_count) > 32'(MAX_POINTS)) begin
            eff_second = 32'(MAX_POINTS);
        end else begin
            eff_second = 32'(r_second_count);
        end
    end

    assign last_first  = IDX_W'(eff_first - 32'd1);
    assign last_second = IDX_W'(eff_second - 32'd1);

    // Load decoding: loads outside the store are dropped.
    assign pidx32 = 32'(i_in_item.point_index);
    assign load_ok = (32'(i_in_item.word_index) < 32'(DESC_WORDS))
                  && (pidx32 < 32'(MAX_POINTS));
    assign first_wr  = in_xfer && load_ok && (i_in_item.kind == hmnm_pkg::KIND_LOAD_FIRST);
    assign second_wr = in_xfer && load_ok && (i_in_item.kind == hmnm_pkg::KIND_LOAD_SECOND);

    // Read ports: key fetch and scan for each store.
    assign first_rd      = (r_state == S_KEY1) || (r_state == S_SCAN1);
    assign first_rd_row  = (r_state == S_KEY1) ? r_q : r_cnt;
    assign second_rd     = (r_state == S_KEY2) || (r_state == S_SCAN2);
    assign second_rd_row = (r_state == S_KEY2) ? r_match : r_cnt;

    assign dist_clear = (r_state == S_KEYW1) || (r_state == S_KEYW2);

    hmnm_store #(
        .ROWS  (MAX_POINTS),
        .WORDS (DESC_WORDS)
    ) u_first_store (
        .i_clk     (i_clk),
        .i_wr_en   (first_wr),
        .i_wr_row  (IDX_W'(pidx32)),
        .i_wr_word (WSEL_W'(i_in_item.word_index)),
        .i_wr_data (i_in_item.word_value),
        .i_rd_en   (first_rd),
        .i_rd_row  (first_rd_row),
        .o_rd_data (first_rd_data)
    );

    hmnm_store #(
        .ROWS  (MAX_POINTS),
        .WORDS (DESC_WORDS)
    ) u_second_store (
        .i_clk     (i_clk),
        .i_wr_en   (second_wr),
        .i_wr_row  (IDX_W'(pidx32)),
        .i_wr_word (WSEL_W'(i_in_item.word_index)),
        .i_wr_data (i_in_item.word_value),
        .i_rd_en   (second_rd),
        .i_rd_row  (second_rd_row),
        .o_rd_data (second_rd_data)
    );

    hmnm_dist #(
        .WORDS (DESC_WORDS),
        .IDX_W (IDX_W),
        .DW    (DW)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (r_key),
        .i_clear      (dist_clear),
        .i_cand_valid (r_iss_v),
        .i_cand_index (r_iss_idx),
        .i_cand_data  (r_iss_sel ? second_rd_data : first_rd_data),
        .o_busy       (dist_busy),
        .o_best_index (best_index),
        .o_best_dist  (best_dist)
    );

    // Result fields, with the distance saturated to the field range.
    assign match32 = 32'(r_match);
    assign dist32  = 32'(r_mdist);

    // Query sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss_v     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // One candidate goes to the distance unit in every scan cycle.
            r_iss_v <= (r_state == S_SCAN2) || (r_state == S_SCAN1);
            // The result register fills when a query finishes and empties on a transfer.
            if ((r_state == S_OUT) && (!o_out_valid || out_xfer)) begin
                o_out_valid <= 1'b1;
            end else if (out_xfer) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_in_item.kind == hmnm_pkg::KIND_QUERY) begin
                        r_q      <= IDX_W'(pidx32);
                        r_bad    <= (pidx32 >= eff_first);
                        r_match  <= '0;
                        r_mdist  <= '0;
                        r_mutual <= 1'b0;
                        r_state  <= (pidx32 >= eff_first) ? S_OUT : S_KEY1;
                    end
                end
                S_KEY1: begin
                    r_state <= S_KEYW1;
                end
                S_KEYW1: begin
                    r_key   <= first_rd_data;
                    r_cnt   <= '0;
                    r_last  <= last_second;
                    r_state <= S_SCAN2;
                end
                S_SCAN2: begin
                    r_iss_sel <= 1'b1;
                    r_iss_idx <= r_cnt;
                    if (r_cnt == r_last) begin
                        r_state <= S_DRAIN2;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_DRAIN2: begin
                    if (!r_iss_v && !dist_busy) begin
                        r_match <= best_index;
                        r_mdist <= best_dist;
                        r_state <= S_KEY2;
                    end
                end
                S_KEY2: begin
                    r_state <= S_KEYW2;
                end
                S_KEYW2: begin
                    r_key   <= second_rd_data;
                    r_cnt   <= '0;
                    r_last  <= last_first;
                    r_state <= S_SCAN1;
                end
                S_SCAN1: begin
                    r_iss_sel <= 1'b0;
                    r_iss_idx <= r_cnt;
                    if (r_cnt == r_last) begin
                        r_state <= S_DRAIN1;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_DRAIN1: begin
                    if (!r_iss_v && !dist_busy) begin
                        r_mutual <= (best_index == r_q);
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || out_xfer) begin
                        o_out_item.match_index     <= match32[hmnm_pkg::MIDX_W-1:0];
                        o_out_item.match_distance  <= (dist32 > 32'(hmnm_pkg::DIST_MAX))
                            ? hmnm_pkg::MDIST_W'(hmnm_pkg::DIST_MAX)
                            : dist32[hmnm_pkg::MDIST_W-1:0];
                        o_out_item.is_mutual       <= r_mutual;
                        o_out_item.bad_query       <= r_bad;
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/tb_hamming_mutual_nearest_match_top.sv
// Self-checking testbench for the mutual nearest matcher: directed table, bulk load and random phases.
`timescale 1ns / 1ps

module tb_hamming_mutual_nearest_match_top;

    localparam int CLK_PERIOD    = 8;
    localparam int MAX_POINTS    = 1024;
    localparam int DESC_WORDS    = 6;
    localparam int DESC_BITS     = DESC_WORDS * hmnm_pkg::WORD_W;
    localparam int STORE_DEPTH   = MAX_POINTS * DESC_WORDS;
    localparam int BASE_COUNT    = 4;
    localparam int FILL_POINTS   = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 800000;

    localparam logic [hmnm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [hmnm_pkg::WORD_W-1:0] ALL_ONES    = '1;

    typedef struct {
        hmnm_pkg::t_in_item  item;
        bit                  typed;
        hmnm_pkg::t_out_item want;
    } t_table_row;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    hmnm_pkg::t_in_item            in_item   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    hmnm_pkg::t_out_item           out_item;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = hmnm_pkg::CFG_FIRST_COUNT;
    logic [hmnm_pkg::COUNT_W-1:0]  cfg_data  = '0;

    // Shadow copy of the block's stores and count registers.
    logic [hmnm_pkg::WORD_W-1:0]   first_words  [STORE_DEPTH];
    logic [hmnm_pkg::WORD_W-1:0]   second_words [STORE_DEPTH];
    logic [hmnm_pkg::COUNT_W-1:0]  first_count_cfg  = hmnm_pkg::COUNT_W'(1);
    logic [hmnm_pkg::COUNT_W-1:0]  second_count_cfg = hmnm_pkg::COUNT_W'(1);

    hmnm_pkg::t_out_item           expected_matches [$];
    t_table_row                    directed_rows [$];
    int                            faults      = 0;
    int                            cycle_count = 0;
    int                            burst_left  = 0;
    int                            stall_mode  = 0;
    int                            stall_run   = 0;

    hamming_mutual_nearest_match_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A count of zero behaves as one, and anything past the store size as the store size.
    function automatic int active_points(input logic [hmnm_pkg::COUNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > MAX_POINTS) return MAX_POINTS;
        return int'(c);
    endfunction

    function automatic logic [DESC_BITS-1:0] read_desc(input bit from_first, input int p);
        logic [DESC_BITS-1:0] d;
        for (int w = 0; w < DESC_WORDS; w++) begin
            d[w*hmnm_pkg::WORD_W +: hmnm_pkg::WORD_W] =
                from_first ? first_words[p*DESC_WORDS + w] : second_words[p*DESC_WORDS + w];
        end
        return d;
    endfunction

    // Closest descriptor of one set to the key; the lowest index wins a tie.
    function automatic int nearest_point(input logic [DESC_BITS-1:0] key, input bit in_first,
                                         input int n, output int gap);
        int best;
        int d;
        best = 0;
        gap  = DESC_BITS + 1;
        for (int i = 0; i < n; i++) begin
            d = $countones(key ^ read_desc(in_first, i));
            if (d < gap) begin
                gap  = d;
                best = i;
            end
        end
        return best;
    endfunction

    // Forward match of a first-set point, then the back match that decides mutuality.
    function automatic hmnm_pkg::t_out_item predict_match(input int q);
        hmnm_pkg::t_out_item r;
        int                  n1;
        int                  n2;
        int                  m;
        int                  back;
        int                  d;
        int                  dback;
        r  = '0;
        n1 = active_points(first_count_cfg);
        n2 = active_points(second_count_cfg);
        if (q >= n1) begin
            r.bad_query = 1'b1;
            return r;
        end
        m    = nearest_point(read_desc(1'b1, q), 1'b0, n2, d);
        back = nearest_point(read_desc(1'b0, m), 1'b1, n1, dback);
        r.match_index    = hmnm_pkg::MIDX_W'(m);
        r.match_distance = hmnm_pkg::MDIST_W'((d > hmnm_pkg::DIST_MAX) ? hmnm_pkg::DIST_MAX : d);
        r.is_mutual      = (back == q);
        return r;
    endfunction

    function automatic hmnm_pkg::t_in_item make_item(input logic [hmnm_pkg::KIND_W-1:0] kind,
                                                     input int point, input int word,
                                                     input logic [hmnm_pkg::WORD_W-1:0] value);
        hmnm_pkg::t_in_item it;
        it.kind        = kind;
        it.point_index = hmnm_pkg::PIDX_W'(point);
        it.word_index  = hmnm_pkg::WIDX_W'(word);
        it.word_value  = value;
        return it;
    endfunction

    function automatic hmnm_pkg::t_out_item make_result(input int m, input int d,
                                                        input bit mutual, input bit bad);
        hmnm_pkg::t_out_item r;
        r.match_index    = hmnm_pkg::MIDX_W'(m);
        r.match_distance = hmnm_pkg::MDIST_W'(d);
        r.is_mutual      = mutual;
        r.bad_query      = bad;
        return r;
    endfunction

    task automatic add_row(input logic [hmnm_pkg::KIND_W-1:0] kind, input int point,
                           input int word, input logic [hmnm_pkg::WORD_W-1:0] value,
                           input bit typed, input hmnm_pkg::t_out_item want);
        t_table_row row;
        row.item  = make_item(kind, point, word, value);
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endtask

    task automatic report_fault(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        faults++;
    endtask

    task automatic wait_drain();
        while (expected_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one item, update the shadow state on its transfer, then idle as the burst dictates.
    // With hold set the sender stays quiet until every pending result has arrived.
    task automatic send_item(input hmnm_pkg::t_in_item it, input bit typed,
                             input hmnm_pkg::t_out_item want, input bit hold);
        int gap;
        int addr;
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        addr = int'(it.point_index) * DESC_WORDS + int'(it.word_index);
        case (it.kind)
            hmnm_pkg::KIND_LOAD_FIRST: begin
                if (it.word_index < DESC_WORDS) first_words[addr] = it.word_value;
            end
            hmnm_pkg::KIND_LOAD_SECOND: begin
                if (it.word_index < DESC_WORDS) second_words[addr] = it.word_value;
            end
            hmnm_pkg::KIND_QUERY: begin
                expected_matches = {expected_matches,
                                    typed ? want : predict_match(int'(it.point_index))};
            end
            default: begin
            end
        endcase
        if (hold || burst_left == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            if (hold) begin
                wait_drain();
            end else begin
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Both count registers are written back to back while the block is idle.
    task automatic write_counts(input int first_n, input int second_n);
        cfg_index <= hmnm_pkg::CFG_FIRST_COUNT;
        cfg_data  <= hmnm_pkg::COUNT_W'(first_n);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        first_count_cfg = hmnm_pkg::COUNT_W'(first_n);
        cfg_index <= hmnm_pkg::CFG_SECOND_COUNT;
        cfg_data  <= hmnm_pkg::COUNT_W'(second_n);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        second_count_cfg = hmnm_pkg::COUNT_W'(second_n);
        cfg_valid <= 1'b0;
    endtask

    // One configuration phase of random traffic: mostly queries and loads that pull
    // descriptors towards each other, with some ignored loads and unused kinds.
    task automatic run_phase(input int first_n, input int second_n, input int items);
        int                          n1;
        int                          n2;
        int                          p;
        int                          w;
        int                          src;
        bit                          to_first;
        logic [hmnm_pkg::WORD_W-1:0] v;
        hmnm_pkg::t_in_item          it;
        write_counts(first_n, second_n);
        n1 = active_points(first_count_cfg);
        n2 = active_points(second_count_cfg);
        for (int i = 0; i < items; i++) begin
            p = $urandom_range(0, 99);
            if (p < 45) begin
                p  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n1 - 1)
                                                  : $urandom_range(0, MAX_POINTS - 1);
                it = make_item(hmnm_pkg::KIND_QUERY, p, $urandom_range(0, 7),
                               {$urandom, $urandom});
            end else if (p < 85) begin
                to_first = $urandom_range(0, 1);
                p = ($urandom_range(0, 99) < 70) ? $urandom_range(0, (to_first ? n1 : n2) - 1)
                                                 : $urandom_range(0, MAX_POINTS - 1);
                w = $urandom_range(0, DESC_WORDS - 1);
                case ($urandom_range(0, 5))
                    0: v = {$urandom, $urandom};
                    1: v = $urandom_range(0, 1) ? ALL_ONES : '0;
                    2, 3: begin
                        // Copy from the other set to create close or exact matches.
                        src = $urandom_range(0, (to_first ? n2 : n1) - 1);
                        v   = to_first ? second_words[src*DESC_WORDS + w]
                                       : first_words[src*DESC_WORDS + w];
                    end
                    default: begin
                        // Copy within the same set so that ties appear.
                        src = $urandom_range(0, (to_first ? n1 : n2) - 1);
                        v   = to_first ? first_words[src*DESC_WORDS + w]
                                       : second_words[src*DESC_WORDS + w];
                    end
                endcase
                if ($urandom_range(0, 1)) begin
                    src    = $urandom_range(0, hmnm_pkg::WORD_W - 1);
                    v[src] = ~v[src];
                end
                it = make_item(to_first ? hmnm_pkg::KIND_LOAD_FIRST : hmnm_pkg::KIND_LOAD_SECOND,
                               p, w, v);
            end else if (p < 93) begin
                it = make_item($urandom_range(0, 1) ? hmnm_pkg::KIND_LOAD_FIRST
                                                    : hmnm_pkg::KIND_LOAD_SECOND,
                               $urandom_range(0, MAX_POINTS - 1),
                               $urandom_range(DESC_WORDS, 7), {$urandom, $urandom});
            end else begin
                it = make_item(KIND_UNUSED, $urandom_range(0, MAX_POINTS - 1),
                               $urandom_range(0, 7), {$urandom, $urandom});
            end
            send_item(it, 1'b0, '0, ($urandom_range(0, 99) < 4) || (i == items - 1));
        end
    endtask

    // Receiver: checks every result transfer and stalls in runs of changing character.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_matches.size() == 0) begin
                report_fault($sformatf("result %h with no query pending", out_item));
            end else begin
                if (out_item.match_index !== expected_matches[0].match_index)
                    report_fault($sformatf("match_index %0d, expected %0d",
                                 out_item.match_index, expected_matches[0].match_index));
                if (out_item.match_distance !== expected_matches[0].match_distance)
                    report_fault($sformatf("match_distance %0d, expected %0d",
                                 out_item.match_distance, expected_matches[0].match_distance));
                if (out_item.is_mutual !== expected_matches[0].is_mutual)
                    report_fault($sformatf("is_mutual %b, expected %b",
                                 out_item.is_mutual, expected_matches[0].is_mutual));
                if (out_item.bad_query !== expected_matches[0].bad_query)
                    report_fault($sformatf("bad_query %b, expected %b",
                                 out_item.bad_query, expected_matches[0].bad_query));
                void'(expected_matches.pop_front());
            end
        end
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(3, 40);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= 1'b1;
            default: out_stall <= (stall_run % 3 != 0);
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [DESC_BITS-1:0] base_desc [BASE_COUNT];
        logic [DESC_BITS-1:0] desc;
        int                   bit_at;

        // Directed table: extremes of the descriptor words, a query outside the first set,
        // ignored loads and the unused kind, all with the counts at their reset value.
        for (int w = 0; w < DESC_WORDS; w++) begin
            add_row(hmnm_pkg::KIND_LOAD_FIRST, 0, w, ALL_ONES, 1'b0, '0);
        end
        for (int w = 0; w < DESC_WORDS; w++) begin
            add_row(hmnm_pkg::KIND_LOAD_SECOND, 0, w, '0, 1'b0, '0);
        end
        add_row(hmnm_pkg::KIND_QUERY, 0, 0, '0, 1'b1, make_result(0, 384, 1'b1, 1'b0));
        add_row(hmnm_pkg::KIND_QUERY, MAX_POINTS - 1, 7, ALL_ONES, 1'b1,
                make_result(0, 0, 1'b0, 1'b1));
        add_row(KIND_UNUSED, MAX_POINTS - 1, 7, ALL_ONES, 1'b0, '0);
        add_row(hmnm_pkg::KIND_LOAD_FIRST, 0, DESC_WORDS, '0, 1'b0, '0);
        add_row(hmnm_pkg::KIND_LOAD_SECOND, 0, 7, ALL_ONES, 1'b0, '0);
        add_row(hmnm_pkg::KIND_QUERY, 0, 0, '0, 1'b1, make_result(0, 384, 1'b1, 1'b0));
        add_row(hmnm_pkg::KIND_LOAD_SECOND, 0, DESC_WORDS - 1, ALL_ONES, 1'b0, '0);
        add_row(hmnm_pkg::KIND_QUERY, 0, 0, '0, 1'b1, make_result(0, 320, 1'b1, 1'b0));
        add_row(hmnm_pkg::KIND_LOAD_FIRST, 0, 2, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
        add_row(hmnm_pkg::KIND_QUERY, 0, 5, ALL_ONES, 1'b0, '0);

        // Cluster centres for the bulk load, two of them at the extremes.
        for (int b = 0; b < BASE_COUNT; b++) begin
            for (int w = 0; w < DESC_WORDS; w++) begin
                base_desc[b][w*hmnm_pkg::WORD_W +: hmnm_pkg::WORD_W] = {$urandom, $urandom};
            end
        end
        base_desc[0] = '0;
        base_desc[1] = '1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want,
                      1'b0);
        end

        // Fill every point that the count settings below can reach, in both stores.
        // Points are small perturbations of shared centres, which gives ties and mutual pairs.
        for (int s = 0; s < 2; s++) begin
            for (int p = 0; p < FILL_POINTS; p++) begin
                desc = base_desc[$urandom_range(0, BASE_COUNT - 1)];
                repeat ($urandom_range(0, 5)) begin
                    bit_at       = $urandom_range(0, DESC_BITS - 1);
                    desc[bit_at] = ~desc[bit_at];
                end
                for (int w = 0; w < DESC_WORDS; w++) begin
                    send_item(make_item((s == 0) ? hmnm_pkg::KIND_LOAD_FIRST
                                                 : hmnm_pkg::KIND_LOAD_SECOND, p, w,
                                        desc[w*hmnm_pkg::WORD_W +: hmnm_pkg::WORD_W]),
                              1'b0, '0,
                              (s == 1) && (p == FILL_POINTS - 1) && (w == DESC_WORDS - 1));
                end
            end
        end

        // Count settings: the filled range, zero counts, single points, then random sets.
        run_phase(FILL_POINTS, FILL_POINTS, 40);
        run_phase(0, 0, 16);
        run_phase(1, FILL_POINTS, 8);
        run_phase(FILL_POINTS, 1, 8);
        repeat (3) run_phase($urandom_range(1, FILL_POINTS), $urandom_range(1, FILL_POINTS), 35);

        wait_drain();
        repeat (20) @(posedge clk);
        if (faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
